[src/e2q_pkg.sv]
`default_nettype none
package e2q_pkg;
	localparam int ATAN_ENTRIES = 24;
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef logic signed [CW-1:0] cval_t;

	typedef struct packed {
		cval_t x;
		cval_t y;
		cval_t z;
		logic  neg;
	} cvec_t;

	function automatic cval_t atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 34'sh3243F6A8;
			5'd1:  atan_q30 = 34'sh1DAC6705;
			5'd2:  atan_q30 = 34'sh0FADBAFC;
			5'd3:  atan_q30 = 34'sh07F56EA6;
			5'd4:  atan_q30 = 34'sh03FEAB76;
			5'd5:  atan_q30 = 34'sh01FFD55B;
			5'd6:  atan_q30 = 34'sh00FFFAAA;
			5'd7:  atan_q30 = 34'sh007FFF55;
			5'd8:  atan_q30 = 34'sh003FFFEA;
			5'd9:  atan_q30 = 34'sh001FFFFD;
			5'd10: atan_q30 = 34'sh000FFFFF;
			5'd11: atan_q30 = 34'sh0007FFFF;
			5'd12: atan_q30 = 34'sh0003FFFF;
			5'd13: atan_q30 = 34'sh0001FFFF;
			5'd14: atan_q30 = 34'sh0000FFFF;
			5'd15: atan_q30 = 34'sh00007FFF;
			5'd16: atan_q30 = 34'sh00003FFF;
			5'd17: atan_q30 = 34'sh00001FFF;
			5'd18: atan_q30 = 34'sh00000FFF;
			5'd19: atan_q30 = 34'sh000007FF;
			5'd20: atan_q30 = 34'sh000003FF;
			5'd21: atan_q30 = 34'sh000001FF;
			5'd22: atan_q30 = 34'sh000000FF;
			5'd23: atan_q30 = 34'sh0000007F;
			default: atan_q30 = '0;
		endcase
	endfunction

	// Q.30 product rounded back to Q.30
	function automatic cval_t mul_q30(input cval_t a, input cval_t b);
		logic signed [2*CW-1:0] p;
		p = a * b + (68'sd1 <<< 29);
		mul_q30 = cval_t'(p >>> 30);
	endfunction
endpackage
`default_nettype wire

[src/euler_to_quaternion.sv]
// Pipeline from an accepted request to out_valid: one fold stage, the CORDIC stages,
// three product/sum stages and the output register.
// Throughput: one request per cycle; a stall freezes the whole pipeline.
// Reset clears the stage valid bits and the output valid only.
`default_nettype none
module euler_to_quaternion import e2q_pkg::*; #(
	parameter int SINCOS_STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] roll_angle,
	input  wire logic [15:0] pitch_angle,
	input  wire logic [15:0] yaw_angle,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      quat_w,
	output logic [15:0]      quat_x,
	output logic [15:0]      quat_y,
	output logic [15:0]      quat_z
);
	localparam int N = (SINCOS_STAGES < ATAN_ENTRIES) ? SINCOS_STAGES : ATAN_ENTRIES;
	localparam int DEPTH = N + 4;

	logic [DEPTH-1:0] vld_q;
	logic en;
	cval_t sr, cr, sp, cp, sy, cy;
	logic [15:0] w, x, y, z;

	// pipeline advances unless a finished request is blocked at the output
	assign en = !(out_valid && !out_ready);
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
			out_valid <= vld_q[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_w <= w;
			quat_x <= x;
			quat_y <= y;
			quat_z <= z;
		end
	end

	e2q_cordic #(.STAGES(SINCOS_STAGES)) u_roll (
		.clk(clk), .en(en), .angle(roll_angle), .sin_q30(sr), .cos_q30(cr));
	e2q_cordic #(.STAGES(SINCOS_STAGES)) u_pitch (
		.clk(clk), .en(en), .angle(pitch_angle), .sin_q30(sp), .cos_q30(cp));
	e2q_cordic #(.STAGES(SINCOS_STAGES)) u_yaw (
		.clk(clk), .en(en), .angle(yaw_angle), .sin_q30(sy), .cos_q30(cy));

	e2q_combine u_comb (
		.clk(clk), .en(en), .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
		.w(w), .x(x), .y(y), .z(z));

	// a blocked output holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_w))
		else $error("output changed under stall");
	// input is ready exactly when the output is not stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == !(out_valid && !out_ready))
		else $error("ready mismatch");
endmodule
`default_nettype wire

[src/e2q_cordic.sv]
`default_nettype none
// Pipelined rotation-mode CORDIC, one iteration per register stage
module e2q_cordic import e2q_pkg::*; #(
	parameter int STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [15:0] angle,
	output cval_t            sin_q30,
	output cval_t            cos_q30
);
	localparam int N = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

	cvec_t pipe_s1 [N+1];
	cval_t half;

	// half angle in Q.30; the first stage folds it into +-pi/2
	assign half = cval_t'($signed(angle)) <<< 17;

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s1[0].x <= CORDIC_GAIN;
			pipe_s1[0].y <= '0;
			if (half > HALF_PI_Q30) begin
				pipe_s1[0].z <= half - PI_Q30;
				pipe_s1[0].neg <= 1'b1;
			end else if (half < -HALF_PI_Q30) begin
				pipe_s1[0].z <= half + PI_Q30;
				pipe_s1[0].neg <= 1'b1;
			end else begin
				pipe_s1[0].z <= half;
				pipe_s1[0].neg <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s1[i+1].neg <= pipe_s1[i].neg;
				if (!pipe_s1[i].z[CW-1]) begin
					pipe_s1[i+1].x <= pipe_s1[i].x - (pipe_s1[i].y >>> i);
					pipe_s1[i+1].y <= pipe_s1[i].y + (pipe_s1[i].x >>> i);
					pipe_s1[i+1].z <= pipe_s1[i].z - atan_q30(5'(i));
				end else begin
					pipe_s1[i+1].x <= pipe_s1[i].x + (pipe_s1[i].y >>> i);
					pipe_s1[i+1].y <= pipe_s1[i].y - (pipe_s1[i].x >>> i);
					pipe_s1[i+1].z <= pipe_s1[i].z + atan_q30(5'(i));
				end
			end
		end
	end

	assign sin_q30 = pipe_s1[N].neg ? -pipe_s1[N].y : pipe_s1[N].y;
	assign cos_q30 = pipe_s1[N].neg ? -pipe_s1[N].x : pipe_s1[N].x;
endmodule
`default_nettype wire

[src/e2q_combine.sv]
`default_nettype none
// Half-angle products into quaternion, three register stages
module e2q_combine import e2q_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  cval_t            sr,
	input  cval_t            cr,
	input  cval_t            sp,
	input  cval_t            cp,
	input  cval_t            sy,
	input  cval_t            cy,
	output logic [15:0]      w,
	output logic [15:0]      x,
	output logic [15:0]      y,
	output logic [15:0]      z
);
	cval_t sr_s1, cr_s1, cpcy_s1, spsy_s1, spcy_s1, cpsy_s1;
	cval_t a_s2 [8];
	logic signed [CW:0] q_s3 [4];

	function automatic logic [15:0] to_q15(input logic signed [CW:0] v);
		logic signed [CW:0] r;
		r = (v + (35'sd1 <<< 14)) >>> 15;
		if (r > 35'sd32767) to_q15 = 16'h7FFF;
		else if (r < -35'sd32768) to_q15 = 16'h8000;
		else to_q15 = r[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			// pitch and yaw products
			sr_s1 <= sr;
			cr_s1 <= cr;
			cpcy_s1 <= mul_q30(cp, cy);
			spsy_s1 <= mul_q30(sp, sy);
			spcy_s1 <= mul_q30(sp, cy);
			cpsy_s1 <= mul_q30(cp, sy);
			// roll products
			a_s2[0] <= mul_q30(cr_s1, cpcy_s1);
			a_s2[1] <= mul_q30(sr_s1, spsy_s1);
			a_s2[2] <= mul_q30(sr_s1, cpcy_s1);
			a_s2[3] <= mul_q30(cr_s1, spsy_s1);
			a_s2[4] <= mul_q30(cr_s1, spcy_s1);
			a_s2[5] <= mul_q30(sr_s1, cpsy_s1);
			a_s2[6] <= mul_q30(cr_s1, cpsy_s1);
			a_s2[7] <= mul_q30(sr_s1, spcy_s1);
			// sums
			q_s3[0] <= 35'(a_s2[0]) + 35'(a_s2[1]);
			q_s3[1] <= 35'(a_s2[2]) - 35'(a_s2[3]);
			q_s3[2] <= 35'(a_s2[4]) + 35'(a_s2[5]);
			q_s3[3] <= 35'(a_s2[6]) - 35'(a_s2[7]);
		end
	end

	assign w = to_q15(q_s3[0]);
	assign x = to_q15(q_s3[1]);
	assign y = to_q15(q_s3[2]);
	assign z = to_q15(q_s3[3]);
endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import e2q_pkg::*;

	localparam int STAGES = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = STAGES + 10;
	localparam int HOLD_CYCLES = 250;
	localparam longint GAIN_Q30 = 64'd652032874;
	localparam longint PI_Q30L = 64'd3373259426;
	localparam longint HALF_PI_Q30L = 64'd1686629713;
	localparam longint ARCTAN_Q30[24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
		64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	typedef struct packed {
		logic [15:0] w;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} quat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] roll_angle = '0;
	logic [15:0] pitch_angle = '0;
	logic [15:0] yaw_angle = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] quat_w, quat_x, quat_y, quat_z;

	quat_t quat_q[$];
	int    mismatches = 0;
	int    quiet_cycles = 0;
	bit    calm = 1'b0;
	bit    hold_req = 1'b0;
	bit    hold_ack = 1'b0;
	int    hold_left = 0;

	euler_to_quaternion #(.SINCOS_STAGES(STAGES)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
	);

	always #5 clk = ~clk;

	// half-angle sine and cosine, Q.30, with quadrant fold
	function automatic void half_sincos(input logic [15:0] ang, output longint s,
		output longint c);
		longint xv, yv, zv, xs, ys;
		bit     flip;
		xv = GAIN_Q30;
		yv = 0;
		zv = longint'($signed(ang)) * 131072;
		flip = 1'b0;
		if (zv > HALF_PI_Q30L) begin
			zv = zv - PI_Q30L;
			flip = 1'b1;
		end else if (zv < -HALF_PI_Q30L) begin
			zv = zv + PI_Q30L;
			flip = 1'b1;
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			xs = xv >>> i;
			ys = yv >>> i;
			if (zv >= 0) begin
				xv = xv - ys;
				yv = yv + xs;
				zv = zv - ARCTAN_Q30[i];
			end else begin
				xv = xv + ys;
				yv = yv - xs;
				zv = zv + ARCTAN_Q30[i];
			end
		end
		s = flip ? -yv : yv;
		c = flip ? -xv : xv;
	endfunction

	function automatic longint prod_q30(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic logic [15:0] sat_q15(input longint v);
		longint r;
		r = (v + (64'sd1 <<< 14)) >>> 15;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	// quaternion from roll, pitch and yaw
	function automatic quat_t euler_quat(input logic [15:0] r, input logic [15:0] p,
		input logic [15:0] yw);
		longint sr, cr, sp, cp, sy, cy, cpcy, spsy, spcy, cpsy;
		quat_t  q;
		half_sincos(r, sr, cr);
		half_sincos(p, sp, cp);
		half_sincos(yw, sy, cy);
		cpcy = prod_q30(cp, cy);
		spsy = prod_q30(sp, sy);
		spcy = prod_q30(sp, cy);
		cpsy = prod_q30(cp, sy);
		q.w = sat_q15(prod_q30(cr, cpcy) + prod_q30(sr, spsy));
		q.x = sat_q15(prod_q30(sr, cpcy) - prod_q30(cr, spsy));
		q.y = sat_q15(prod_q30(cr, spcy) + prod_q30(sr, cpsy));
		q.z = sat_q15(prod_q30(cr, cpsy) - prod_q30(sr, spcy));
		return q;
	endfunction

	// offer one request and wait until it is taken
	task automatic send_angles(input logic [15:0] r, input logic [15:0] p,
		input logic [15:0] yw);
		in_valid <= 1'b1;
		roll_angle <= r;
		pitch_angle <= p;
		yaw_angle <= yw;
		do @(posedge clk); while (!in_ready);
		quat_q.push_back(euler_quat(r, p, yw));
	endtask

	task automatic maybe_gap();
		if (!calm && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_empty();
		in_valid <= 1'b0;
		while (quat_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(3))
			0: return 16'($urandom_range(32767, 0) - 16384);
			1: return 16'($urandom_range(13500, 12200) * ($urandom_range(1) ? 1 : -1));
			default: return 16'($urandom);
		endcase
	endfunction

	// extremes of each field and the quadrant-fold boundaries
	task automatic test_directed();
		logic [15:0] vals[10];
		vals = '{16'd0, 16'd1, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd12867, 16'd12868,
			-16'sd12867, -16'sd12868, 16'd25736};
		foreach (vals[i]) begin
			send_angles(vals[i], vals[i], vals[i]);
			maybe_gap();
		end
		send_angles(16'h7FFF, 16'h8000, 16'd0);
		send_angles(16'h8000, 16'd0, 16'h7FFF);
		send_angles(16'd0, 16'h7FFF, 16'h8000);
		send_angles(16'd12868, 16'h8000, 16'd6434);
		send_angles(16'hAAAA, 16'h5555, 16'hFFFF);
		wait_empty();
	endtask

	// random angles, a calm stretch in the middle
	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 3 && i < n / 2);
			send_angles(rand_angle(), rand_angle(), rand_angle());
			maybe_gap();
		end
		calm = 1'b0;
	endtask

	// receiver holds off while requests keep coming, so the pipe fills
	task automatic test_backpressure(input int n);
		hold_req = 1'b1;
		for (int i = 0; i < n; i++)
			send_angles(rand_angle(), rand_angle(), rand_angle());
		hold_req = 1'b0;
	endtask

	// sender stops until every result is back, then resumes
	task automatic test_pause_resume(input int n);
		wait_empty();
		test_random(n);
	endtask

	// result sink with random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_ack) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_ack <= 1'b1;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 38);
		end
	end

	// result check against the oldest prediction
	always @(posedge clk) begin
		quat_t exp_q;
		if (arst_n && out_valid && out_ready) begin
			if (quat_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result w=%h x=%h y=%h z=%h",
						quat_w, quat_x, quat_y, quat_z);
			end else begin
				exp_q = quat_q.pop_front();
				if ({quat_w, quat_x, quat_y, quat_z} !== exp_q) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp w=%h x=%h y=%h z=%h got w=%h x=%h y=%h z=%h",
							exp_q.w, exp_q.x, exp_q.y, exp_q.z,
							quat_w, quat_x, quat_y, quat_z);
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1000);
		test_backpressure(300);
		test_pause_resume(130);
		wait_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += quat_q.size();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
